// File: rtl/pixel_color_space_converter_defines.svh
// Assertion macros used by the queue of the color space converter RTL.
`ifndef PIXEL_COLOR_SPACE_CONVERTER_DEFINES_SVH
`define PIXEL_COLOR_SPACE_CONVERTER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define PCSC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define PCSC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pcsc_pkg.sv
// Types, constants and arithmetic helpers for the pixel color space converter.
`timescale 1ns / 1ps

package pcsc_pkg;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // Color space codes
    localparam logic [2:0] SP_RGB  = 3'd0;
    localparam logic [2:0] SP_HSV  = 3'd1;
    localparam logic [2:0] SP_YUV  = 3'd2;
    localparam logic [2:0] SP_CMY  = 3'd3;
    localparam logic [2:0] SP_CMYK = 3'd4;
    localparam logic [2:0] SP_GRAY = 3'd5;

    // Register indexes
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    typedef enum logic [1:0] {
        MODE_PASS = 2'b00,
        MODE_SAME = 2'b01,
        MODE_CONV = 2'b10
    } mode_t;

    typedef struct packed {
        logic [7:0] in_first;
        logic [7:0] in_second;
        logic [7:0] in_third;
        logic [7:0] in_fourth;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [7:0] out_third;
        logic [7:0] out_fourth;
    } out_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Item handed from the front end to the back end
    typedef struct packed {
        mode_t    mode;
        in_item_t raw;
        rgb_t     rgb;
    } mid_item_t;

    // Saturate a signed intermediate to 0..255
    function automatic logic [7:0] sat8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 0)
        begin
            res = 8'd0;
        end
        else if (v > 11'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    // Floor of x / 3 for x up to 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] m;
        m = {10'd0, x} * 20'd683;
        return m[18:11];
    endfunction

    // Floor of u / 255 for u below 2^24: reciprocal estimate, then correct
    function automatic logic [16:0] div255(input logic [24:0] u);
        logic [25:0] e;
        logic [16:0] q;
        logic [24:0] rem;
        e   = {1'b0, u} + {9'd0, u[24:8]} + {17'd0, u[24:16]};
        q   = e[24:8];
        rem = u - (25'({q, 8'd0}) - 25'(q));
        if (rem >= 25'd255)
        begin
            q   = q + 17'd1;
            rem = rem - 25'd255;
        end
        if (rem >= 25'd255)
        begin
            q = q + 17'd1;
        end
        return q;
    endfunction

endpackage

// File: rtl/pcsc_fifo.sv
// Small register queue that decouples two pipeline sections.
`timescale 1ns / 1ps
`include "pixel_color_space_converter_defines.svh"

module pcsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] din,
    input  logic             rd_en,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // Advance pointers with wrap at the depth and track the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    `PCSC_ASSERT_SAME(a_no_overflow, clk, rst_n, wr_en && full, rd_en, "write into full queue")
    `PCSC_ASSERT_SAME(a_no_underflow, clk, rst_n, rd_en, !empty, "read from empty queue")
    `PCSC_ASSERT_NEXT(a_count_up, clk, rst_n, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1, "count did not rise")

endmodule

// File: rtl/pcsc_front.sv
// Front end: accept items, classify the space pair and convert the source to RGB.
`timescale 1ns / 1ps

module pcsc_front
    import pcsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] source_space,
    input  logic [2:0] target_space,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       mid_valid,
    input  logic       mid_ready,
    output mid_item_t  mid_item
);

    localparam int NS = 5;

    logic      v_reg [NS];
    in_item_t  raw_reg [NS];
    mode_t     mode_reg [NS];
    rgb_t      srgb_reg [NS];
    logic [2:0] sector_reg [NS];

    logic [7:0]  f1_reg;
    logic [15:0] sf2_reg, stf2_reg;
    logic [15:0] yp3_reg;
    logic [23:0] yq3_reg, yt3_reg;
    logic [7:0]  p4_reg;
    logic [16:0] q14_reg, t14_reg;
    logic [7:0]  p5_reg, q5_reg, t5_reg;

    logic        en;
    mode_t       mode_next;
    rgb_t        srgb_next;
    logic [10:0] six;
    logic [10:0] base;
    logic [2:0]  sector_raw;
    logic [2:0]  sector_next;
    logic [7:0]  f_next;
    logic [15:0] sf_next, stf_next;
    logic [15:0] yp_next;
    logic [23:0] yq_next, yt_next;
    logic [16:0] wq, wt;
    logic [16:0] p_full;
    logic [7:0]  p_next;
    logic [16:0] q1_next, t1_next;
    logic [16:0] q_full, t_full;
    rgb_t        hrgb;

    // Stall the whole section only while its last stage cannot drain
    assign en       = !v_reg[NS-1] || mid_ready;
    assign in_ready = en;

    // Classify the pair and convert the simple source spaces
    always_comb
    begin
        if (source_space > SP_GRAY || target_space > SP_GRAY)
        begin
            mode_next = MODE_PASS;
        end
        else if (source_space == target_space)
        begin
            mode_next = MODE_SAME;
        end
        else
        begin
            mode_next = MODE_CONV;
        end

        unique case (source_space)
            SP_YUV:
            begin
                srgb_next.r = in_item.in_third;
                srgb_next.b = in_item.in_second;
                srgb_next.g = sat8(11'sd3 * $signed({3'd0, in_item.in_first})
                                   - $signed({3'd0, in_item.in_third})
                                   - $signed({3'd0, in_item.in_second}));
            end
            SP_CMY:
            begin
                srgb_next.r = 8'd255 - in_item.in_first;
                srgb_next.g = 8'd255 - in_item.in_second;
                srgb_next.b = 8'd255 - in_item.in_third;
            end
            SP_CMYK:
            begin
                srgb_next.r = sat8(11'sd255 - $signed({3'd0, in_item.in_first})
                                   - $signed({3'd0, in_item.in_fourth}));
                srgb_next.g = sat8(11'sd255 - $signed({3'd0, in_item.in_second})
                                   - $signed({3'd0, in_item.in_fourth}));
                srgb_next.b = sat8(11'sd255 - $signed({3'd0, in_item.in_third})
                                   - $signed({3'd0, in_item.in_fourth}));
            end
            SP_GRAY:
            begin
                srgb_next.r = in_item.in_first;
                srgb_next.g = in_item.in_first;
                srgb_next.b = in_item.in_first;
            end
            default:
            begin
                srgb_next.r = in_item.in_first;
                srgb_next.g = in_item.in_second;
                srgb_next.b = in_item.in_third;
            end
        endcase
    end

    // Split six times the hue byte into sector and fraction
    always_comb
    begin
        six = (11'(in_item.in_first) << 2) + (11'(in_item.in_first) << 1);
        priority if (six >= 11'd1530)
        begin
            sector_raw = 3'd6;
            base       = 11'd1530;
        end
        else if (six >= 11'd1275)
        begin
            sector_raw = 3'd5;
            base       = 11'd1275;
        end
        else if (six >= 11'd1020)
        begin
            sector_raw = 3'd4;
            base       = 11'd1020;
        end
        else if (six >= 11'd765)
        begin
            sector_raw = 3'd3;
            base       = 11'd765;
        end
        else if (six >= 11'd510)
        begin
            sector_raw = 3'd2;
            base       = 11'd510;
        end
        else if (six >= 11'd255)
        begin
            sector_raw = 3'd1;
            base       = 11'd255;
        end
        else
        begin
            sector_raw = 3'd0;
            base       = 11'd0;
        end
        f_next      = 8'(six - base);
        sector_next = (sector_raw == 3'd6) ? 3'd0 : sector_raw;
    end

    // HSV datapath: products, then scaled products, then divisions by 255
    always_comb
    begin
        sf_next  = raw_reg[0].in_second * f1_reg;
        stf_next = raw_reg[0].in_second * (8'd255 - f1_reg);
        wq       = 17'd65025 - 17'(sf2_reg);
        wt       = 17'd65025 - 17'(stf2_reg);
        yp_next  = raw_reg[1].in_third * (8'd255 - raw_reg[1].in_second);
        yq_next  = 24'(raw_reg[1].in_third * wq);
        yt_next  = 24'(raw_reg[1].in_third * wt);
        p_full   = div255(25'(yp3_reg) + 25'd127);
        p_next   = p_full[7:0];
        q1_next  = div255(25'(yq3_reg) + 25'd32512);
        t1_next  = div255(25'(yt3_reg) + 25'd32512);
        q_full   = div255(25'(q14_reg));
        t_full   = div255(25'(t14_reg));
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg[0]    <= in_item;
            mode_reg[0]   <= mode_next;
            srgb_reg[0]   <= srgb_next;
            sector_reg[0] <= sector_next;
            for (int i = 1; i < NS; i++)
            begin
                raw_reg[i]    <= raw_reg[i-1];
                mode_reg[i]   <= mode_reg[i-1];
                srgb_reg[i]   <= srgb_reg[i-1];
                sector_reg[i] <= sector_reg[i-1];
            end
            f1_reg   <= f_next;
            sf2_reg  <= sf_next;
            stf2_reg <= stf_next;
            yp3_reg  <= yp_next;
            yq3_reg  <= yq_next;
            yt3_reg  <= yt_next;
            p4_reg   <= p_next;
            q14_reg  <= q1_next;
            t14_reg  <= t1_next;
            p5_reg   <= p4_reg;
            q5_reg   <= q_full[7:0];
            t5_reg   <= t_full[7:0];
        end
    end

    // Pick the RGB order by hue sector
    always_comb
    begin
        unique case (sector_reg[NS-1])
            3'd0:    hrgb = '{r: raw_reg[NS-1].in_third, g: t5_reg, b: p5_reg};
            3'd1:    hrgb = '{r: q5_reg, g: raw_reg[NS-1].in_third, b: p5_reg};
            3'd2:    hrgb = '{r: p5_reg, g: raw_reg[NS-1].in_third, b: t5_reg};
            3'd3:    hrgb = '{r: p5_reg, g: q5_reg, b: raw_reg[NS-1].in_third};
            3'd4:    hrgb = '{r: t5_reg, g: p5_reg, b: raw_reg[NS-1].in_third};
            default: hrgb = '{r: raw_reg[NS-1].in_third, g: p5_reg, b: q5_reg};
        endcase
    end

    assign mid_valid     = v_reg[NS-1];
    assign mid_item.mode = mode_reg[NS-1];
    assign mid_item.raw  = raw_reg[NS-1];
    assign mid_item.rgb  = (source_space == SP_HSV) ? hrgb : srgb_reg[NS-1];

endmodule

// File: rtl/pcsc_back.sv
// Back end: convert RGB to the target space, with a pipelined divider for HSV.
`timescale 1ns / 1ps

module pcsc_back
    import pcsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] source_space,
    input  logic [2:0] target_space,
    input  logic       mid_valid,
    output logic       mid_pop,
    input  mid_item_t  mid_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    localparam int ND = 5;

    logic        v0_reg;
    mid_item_t   b0_reg;
    logic        vd_reg [ND];
    out_item_t   res_reg [ND];
    logic        hsv_reg [ND];
    logic [16:0] rem_s_reg [ND];
    logic [19:0] rem_h_reg [ND];
    logic [8:0]  div_s_reg [ND];
    logic [11:0] div_h_reg [ND];
    logic [7:0]  q_s_reg [ND];
    logic [7:0]  q_h_reg [ND];

    logic [16:0] rem_s_next [ND];
    logic [19:0] rem_h_next [ND];
    logic [7:0]  q_s_next [ND];
    logic [7:0]  q_h_next [ND];

    logic        en;
    logic [7:0]  r, g, b, mx, mn, d;
    logic [10:0] n, d6;
    logic [9:0]  sum;
    logic [7:0]  avg;
    out_item_t   res_next;
    logic        hsv_next;

    // Stall the section only while its last stage cannot drain
    assign en      = !vd_reg[ND-1] || out_ready;
    assign mid_pop = en && mid_valid;

    // Extremes, hue numerator and the non-divider targets
    always_comb
    begin
        r   = b0_reg.rgb.r;
        g   = b0_reg.rgb.g;
        b   = b0_reg.rgb.b;
        mx  = r;
        mn  = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d   = mx - mn;
        d6  = (11'(d) << 2) + (11'(d) << 1);
        priority if (r == mx)
        begin
            n = (g >= b) ? 11'(g - b) : d6 - 11'(b - g);
        end
        else if (g == mx)
        begin
            n = (11'(d) << 1) + 11'(b) - 11'(r);
        end
        else
        begin
            n = (11'(d) << 2) + 11'(r) - 11'(g);
        end
        sum      = 10'(r) + 10'(g) + 10'(b);
        avg      = div3(sum);
        hsv_next = 1'b0;
        res_next = '0;

        priority if (b0_reg.mode == MODE_PASS)
        begin
            res_next = out_item_t'(b0_reg.raw);
        end
        else if (b0_reg.mode == MODE_SAME)
        begin
            res_next.out_first  = b0_reg.raw.in_first;
            res_next.out_second = (source_space == SP_GRAY) ? 8'd0 : b0_reg.raw.in_second;
            res_next.out_third  = (source_space == SP_GRAY) ? 8'd0 : b0_reg.raw.in_third;
            res_next.out_fourth = (source_space == SP_CMYK) ? b0_reg.raw.in_fourth : 8'd0;
        end
        else
        begin
            unique case (target_space)
                SP_HSV:
                begin
                    hsv_next          = 1'b1;
                    res_next.out_third = mx;
                end
                SP_YUV:
                begin
                    res_next.out_first  = avg;
                    res_next.out_second = b;
                    res_next.out_third  = r;
                end
                SP_CMY:
                begin
                    res_next.out_first  = 8'd255 - r;
                    res_next.out_second = 8'd255 - g;
                    res_next.out_third  = 8'd255 - b;
                end
                SP_CMYK:
                begin
                    res_next.out_first  = mx - r;
                    res_next.out_second = mx - g;
                    res_next.out_third  = mx - b;
                    res_next.out_fourth = 8'd255 - mx;
                end
                SP_GRAY:
                begin
                    res_next.out_first = avg;
                end
                default:
                begin
                    res_next.out_first  = r;
                    res_next.out_second = g;
                    res_next.out_third  = b;
                end
            endcase
        end
    end

    // Restoring divider, two quotient bits per stage
    always_comb
    begin
        logic [27:0] rs, rh;
        logic [7:0]  qs, qh;
        rem_s_next[0] = '0;
        rem_h_next[0] = '0;
        q_s_next[0]   = '0;
        q_h_next[0]   = '0;
        for (int i = 0; i < ND - 1; i++)
        begin
            rs = 28'(rem_s_reg[i]);
            rh = 28'(rem_h_reg[i]);
            qs = q_s_reg[i];
            qh = q_h_reg[i];
            for (int j = 0; j < 2; j++)
            begin
                if (rs >= (28'(div_s_reg[i]) << (7 - 2 * i - j)))
                begin
                    rs = rs - (28'(div_s_reg[i]) << (7 - 2 * i - j));
                    qs[7 - 2 * i - j] = 1'b1;
                end
                if (rh >= (28'(div_h_reg[i]) << (7 - 2 * i - j)))
                begin
                    rh = rh - (28'(div_h_reg[i]) << (7 - 2 * i - j));
                    qh[7 - 2 * i - j] = 1'b1;
                end
            end
            rem_s_next[i+1] = rs[16:0];
            rem_h_next[i+1] = rh[19:0];
            q_s_next[i+1]   = qs;
            q_h_next[i+1]   = qh;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 0; i < ND; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg    <= mid_valid;
            vd_reg[0] <= v0_reg;
            for (int i = 1; i < ND; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    // Advance the payload; a flat pixel gets zero hue and saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg     <= mid_item;
            res_reg[0] <= res_next;
            hsv_reg[0] <= hsv_next;
            q_s_reg[0] <= q_s_next[0];
            q_h_reg[0] <= q_h_next[0];
            if (d == 8'd0)
            begin
                rem_s_reg[0] <= '0;
                rem_h_reg[0] <= '0;
                div_s_reg[0] <= 9'd1;
                div_h_reg[0] <= 12'd1;
            end
            else
            begin
                rem_s_reg[0] <= (17'(d) << 9) - (17'(d) << 1) + 17'(mx);
                rem_h_reg[0] <= (20'(n) << 9) - (20'(n) << 1) + 20'(d6);
                div_s_reg[0] <= {mx, 1'b0};
                div_h_reg[0] <= {d6, 1'b0};
            end
            for (int i = 1; i < ND; i++)
            begin
                res_reg[i]   <= res_reg[i-1];
                hsv_reg[i]   <= hsv_reg[i-1];
                div_s_reg[i] <= div_s_reg[i-1];
                div_h_reg[i] <= div_h_reg[i-1];
                rem_s_reg[i] <= rem_s_next[i];
                rem_h_reg[i] <= rem_h_next[i];
                q_s_reg[i]   <= q_s_next[i];
                q_h_reg[i]   <= q_h_next[i];
            end
        end
    end

    // Merge the quotients into an HSV result
    always_comb
    begin
        out_item = res_reg[ND-1];
        if (hsv_reg[ND-1])
        begin
            out_item.out_first  = q_h_reg[ND-1];
            out_item.out_second = q_s_reg[ND-1];
        end
    end

    assign out_valid = vd_reg[ND-1];

endmodule

// File: rtl/pixel_color_space_converter.sv
// A push runs through the front end, middle queue, back end and result queue.
// Throughput: one item per cycle, set by the fully pipelined HSV multiply and
// divide paths; a stalled result side backs up through two 4-entry queues.
// Reset: asynchronous, active low; clears the pipelines, the queues and both
// space registers (RGB to RGB). No memory clearing pass is needed.
`timescale 1ns / 1ps

module pixel_color_space_converter
    import pcsc_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item
);

    logic [2:0] source_space_reg;
    logic [2:0] target_space_reg;

    logic       front_ready;
    logic       front_valid;
    mid_item_t  front_item;
    logic       mid_ready;
    logic       mq_full, mq_empty;
    logic       mq_pop;
    mid_item_t  mq_item;
    logic       back_valid;
    logic       back_ready;
    out_item_t  back_item;
    logic       oq_full;
    logic       oq_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_space_reg <= SP_RGB;
            target_space_reg <= SP_RGB;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_SOURCE: source_space_reg <= pwdata[2:0];
                REG_TARGET: target_space_reg <= pwdata[2:0];
                default:    source_space_reg <= source_space_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TARGET) ? {29'd0, target_space_reg}
                                             : {29'd0, source_space_reg};

    // Front end
    pcsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_space (source_space_reg),
        .target_space (target_space_reg),
        .in_valid     (push),
        .in_ready     (front_ready),
        .in_item      (in_item),
        .mid_valid    (front_valid),
        .mid_ready    (mid_ready),
        .mid_item     (front_item)
    );

    assign full      = !front_ready;
    assign mid_ready = !mq_full || mq_pop;

    // Queue between front and back
    pcsc_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (front_valid && mid_ready),
        .din   (front_item),
        .rd_en (mq_pop),
        .dout  (mq_item),
        .full  (mq_full),
        .empty (mq_empty)
    );

    // Back end
    pcsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_space (source_space_reg),
        .target_space (target_space_reg),
        .mid_valid    (!mq_empty),
        .mid_pop      (mq_pop),
        .mid_item     (mq_item),
        .out_valid    (back_valid),
        .out_ready    (back_ready),
        .out_item     (back_item)
    );

    assign oq_pop     = pop && !empty;
    assign back_ready = !oq_full || oq_pop;

    // Result queue
    pcsc_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (back_valid && back_ready),
        .din   (back_item),
        .rd_en (oq_pop),
        .dout  (out_item),
        .full  (oq_full),
        .empty (empty)
    );

endmodule
